// ===== src/tsc_pkg.sv =====
// Shared types, constants and codes for the text screen console writer.
package tsc_pkg;

    localparam int COLUMNS      = 80;
    localparam int SCROLL_ROW   = 24;
    localparam int SCREEN_CELLS = COLUMNS * (SCROLL_ROW + 1);
    localparam int CELL_W       = $clog2(SCREEN_CELLS + 1);
    localparam int ADDR_W       = $clog2(SCREEN_CELLS);
    localparam int COL_W        = $clog2(COLUMNS);
    localparam int ROW_W        = $clog2(SCROLL_ROW + 2);
    localparam int MOVE_FIRST   = COLUMNS;
    localparam int MOVE_LAST    = SCROLL_ROW * COLUMNS - 1;
    localparam int CLEAR_END    = SCROLL_ROW * COLUMNS;

    localparam int CODE_W = 9;
    localparam int BYTE_W = 8;
    localparam int DATA_W = 16;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'h00A;
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;
    localparam logic [CODE_W-1:0] CODE_UP        = 9'h0E2;
    localparam logic [CODE_W-1:0] CODE_DOWN      = 9'h0E3;
    localparam logic [CODE_W-1:0] CODE_LEFT      = 9'h0E4;
    localparam logic [CODE_W-1:0] CODE_RIGHT     = 9'h0E5;

    localparam logic [BYTE_W-1:0] BYTE_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h1B;
    localparam logic [BYTE_W-1:0] BYTE_CSI   = 8'h5B;
    localparam logic [BYTE_W-1:0] BYTE_UP    = 8'h41;
    localparam logic [BYTE_W-1:0] BYTE_DOWN  = 8'h42;
    localparam logic [BYTE_W-1:0] BYTE_RIGHT = 8'h43;
    localparam logic [BYTE_W-1:0] BYTE_LEFT  = 8'h44;

    localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h07;

    localparam logic [1:0] LAST_ONE   = 2'd0;
    localparam logic [1:0] LAST_THREE = 2'd2;

    typedef enum logic [2:0] {
        OP_READ,
        OP_CHAR,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_LEFT,
        OP_RIGHT
    } t_op;

    typedef struct packed {
        t_op                          op;
        logic [BYTE_W-1:0]            ch;
        logic [CELL_W-1:0]            addr;
        logic                         ser_valid;
        logic [2:0][BYTE_W-1:0]       ser;
        logic [1:0]                   last_idx;
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDWAIT,
        S_CHECK,
        S_MOVE,
        S_MVEND,
        S_WIPE,
        S_SPACE,
        S_EMIT
    } t_state;

endpackage

// ===== src/tsc_if.sv =====
// Valid/ready channel interfaces: put items, results and attribute writes.
interface tsc_put_if;
    import tsc_pkg::*;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [CODE_W-1:0]   char_code;
    logic [CELL_W-1:0]   cell_address;
    modport source (output valid, kind, char_code, cell_address, input ready);
    modport sink   (input valid, kind, char_code, cell_address, output ready);
endinterface

interface tsc_res_if;
    import tsc_pkg::*;
    logic                valid;
    logic                ready;
    logic                serial_valid;
    logic [BYTE_W-1:0]   serial_byte;
    logic [DATA_W-1:0]   cell_data;
    logic [CELL_W-1:0]   cursor_position;
    logic                last;
    modport source (output valid, serial_valid, serial_byte, cell_data, cursor_position, last,
                    input ready);
    modport sink   (input valid, serial_valid, serial_byte, cell_data, cursor_position, last,
                    output ready);
endinterface

interface tsc_cfg_if;
    import tsc_pkg::*;
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   text_attribute;
    modport source (output valid, text_attribute, input ready);
    modport sink   (input valid, text_attribute, output ready);
endinterface

// ===== src/tsc_front.sv =====
// Front end: accepts put/read transactions and decodes them into commands.
module tsc_front (
    tsc_put_if.sink            i_put,
    input  logic               i_clearing,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output tsc_pkg::t_cmd      o_push_data
);
    import tsc_pkg::*;

    t_cmd cmd;

    assign i_put.ready  = i_push_ready && !i_clearing;
    assign o_push_valid = i_put.valid && !i_clearing;
    assign o_push_data  = cmd;

    always_comb begin
        cmd           = '0;
        cmd.ch        = i_put.char_code[BYTE_W-1:0];
        cmd.addr      = i_put.cell_address;
        cmd.ser_valid = 1'b1;
        cmd.ser[0]    = i_put.char_code[BYTE_W-1:0];
        cmd.last_idx  = LAST_ONE;
        cmd.op        = OP_CHAR;
        if (i_put.kind) begin
            cmd.op        = OP_READ;
            cmd.ser_valid = 1'b0;
            cmd.ser[0]    = '0;
        end else begin
            case (i_put.char_code)
                CODE_NEWLINE: begin
                    cmd.op = OP_NEWLINE;
                end
                CODE_BACKSPACE: begin
                    cmd.op       = OP_BACKSPACE;
                    cmd.ser[0]   = BYTE_BS;
                    cmd.ser[1]   = BYTE_SPACE;
                    cmd.ser[2]   = BYTE_BS;
                    cmd.last_idx = LAST_THREE;
                end
                CODE_LEFT: begin
                    cmd.op       = OP_LEFT;
                    cmd.ser[0]   = BYTE_ESC;
                    cmd.ser[1]   = BYTE_CSI;
                    cmd.ser[2]   = BYTE_LEFT;
                    cmd.last_idx = LAST_THREE;
                end
                CODE_RIGHT: begin
                    cmd.op       = OP_RIGHT;
                    cmd.ser[0]   = BYTE_ESC;
                    cmd.ser[1]   = BYTE_CSI;
                    cmd.ser[2]   = BYTE_RIGHT;
                    cmd.last_idx = LAST_THREE;
                end
                CODE_UP: begin
                    cmd.ser[0]   = BYTE_ESC;
                    cmd.ser[1]   = BYTE_CSI;
                    cmd.ser[2]   = BYTE_UP;
                    cmd.last_idx = LAST_THREE;
                end
                CODE_DOWN: begin
                    cmd.ser[0]   = BYTE_ESC;
                    cmd.ser[1]   = BYTE_CSI;
                    cmd.ser[2]   = BYTE_DOWN;
                    cmd.last_idx = LAST_THREE;
                end
                default: begin
                    cmd.op = OP_CHAR;
                end
            endcase
        end
    end

endmodule

// ===== src/tsc_fifo.sv =====
// Short command queue between the front end and the screen engine.
module tsc_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_valid,
    output logic               o_push_ready,
    input  tsc_pkg::t_cmd      i_push_data,
    output logic               o_pop_valid,
    input  logic               i_pop_ready,
    output tsc_pkg::t_cmd      o_pop_data
);
    import tsc_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              push, pop;

    assign o_push_ready = r_cnt != QCNT_W'(QDEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
        end
        if (pop) begin
            n_rp = (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

// ===== src/tsc_back.sv =====
// Screen engine: cursor, screen memory, scroll sequencer and result output.
module tsc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pop_valid,
    output logic               o_pop_ready,
    input  tsc_pkg::t_cmd      i_pop_data,
    output logic               o_clearing,
    tsc_cfg_if.sink            i_cfg,
    tsc_res_if.source          o_res
);
    import tsc_pkg::*;

    logic [DATA_W-1:0] r_screen [SCREEN_CELLS];
    logic [DATA_W-1:0] r_rdata;

    t_state            r_state, n_state;
    logic [CELL_W-1:0] r_cursor, n_cursor;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [CELL_W-1:0] r_ptr, n_ptr;
    logic [ADDR_W-1:0] r_wa, n_wa;
    logic              r_pend, n_pend;
    t_cmd              r_cmd, n_cmd;
    logic [1:0]        r_idx, n_idx;
    logic [DATA_W-1:0] r_cell, n_cell;
    logic [BYTE_W-1:0] r_attr;

    logic              we, re;
    logic [ADDR_W-1:0] wa, ra;
    logic [DATA_W-1:0] wd;

    logic [CELL_W-1:0] dec_cursor, inc_cursor;
    logic [ROW_W-1:0]  dec_row, inc_row;
    logic [COL_W-1:0]  dec_col, inc_col;

    assign o_pop_ready = r_state == S_IDLE;
    assign o_clearing  = r_state == S_CLEAR;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid           = r_state == S_EMIT;
    assign o_res.serial_valid    = r_cmd.ser_valid;
    assign o_res.serial_byte     = r_cmd.ser[r_idx];
    assign o_res.cell_data       = r_cell;
    assign o_res.cursor_position = r_cursor;
    assign o_res.last            = r_idx == r_cmd.last_idx;

    // cursor step back / forward, keeping row and column in step
    always_comb begin
        dec_cursor = r_cursor;
        dec_row    = r_row;
        dec_col    = r_col;
        if (r_cursor != '0) begin
            dec_cursor = r_cursor - CELL_W'(1);
            if (r_col == '0) begin
                dec_col = COL_W'(COLUMNS - 1);
                dec_row = r_row - ROW_W'(1);
            end else begin
                dec_col = r_col - COL_W'(1);
            end
        end
        inc_cursor = r_cursor + CELL_W'(1);
        if (r_col == COL_W'(COLUMNS - 1)) begin
            inc_col = '0;
            inc_row = r_row + ROW_W'(1);
        end else begin
            inc_col = r_col + COL_W'(1);
            inc_row = r_row;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cursor = r_cursor;
        n_row    = r_row;
        n_col    = r_col;
        n_ptr    = r_ptr;
        n_wa     = r_wa;
        n_pend   = r_pend;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_cell   = r_cell;
        we       = 1'b0;
        wa       = r_cursor[ADDR_W-1:0];
        wd       = '0;
        re       = 1'b0;
        ra       = r_ptr[ADDR_W-1:0];
        case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                wa = r_ptr[ADDR_W-1:0];
                if (r_ptr == CELL_W'(SCREEN_CELLS - 1)) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + CELL_W'(1);
                end
            end
            S_IDLE: begin
                if (i_pop_valid) begin
                    n_cmd  = i_pop_data;
                    n_idx  = '0;
                    n_cell = '0;
                    case (i_pop_data.op)
                        OP_READ: begin
                            if (i_pop_data.addr < CELL_W'(SCREEN_CELLS)) begin
                                re      = 1'b1;
                                ra      = i_pop_data.addr[ADDR_W-1:0];
                                n_state = S_RDWAIT;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                        OP_LEFT: begin
                            n_cursor = dec_cursor;
                            n_row    = dec_row;
                            n_col    = dec_col;
                            n_state  = S_EMIT;
                        end
                        OP_RIGHT: begin
                            if (r_cursor != CELL_W'(SCREEN_CELLS - 1)) begin
                                n_cursor = inc_cursor;
                                n_row    = inc_row;
                                n_col    = inc_col;
                            end
                            n_state = S_EMIT;
                        end
                        OP_NEWLINE: begin
                            n_cursor = r_cursor + CELL_W'(COLUMNS) - CELL_W'(r_col);
                            n_row    = r_row + ROW_W'(1);
                            n_col    = '0;
                            n_state  = S_CHECK;
                        end
                        OP_BACKSPACE: begin
                            n_cursor = dec_cursor;
                            n_row    = dec_row;
                            n_col    = dec_col;
                            n_state  = S_CHECK;
                        end
                        default: begin
                            we       = 1'b1;
                            wa       = r_cursor[ADDR_W-1:0];
                            wd       = {r_attr, i_pop_data.ch};
                            n_cursor = inc_cursor;
                            n_row    = inc_row;
                            n_col    = inc_col;
                            n_state  = S_CHECK;
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                n_cell  = r_rdata;
                n_state = S_EMIT;
            end
            S_CHECK: begin
                if (r_row >= ROW_W'(SCROLL_ROW)) begin
                    n_cursor = r_cursor - CELL_W'(COLUMNS);
                    n_row    = r_row - ROW_W'(1);
                    n_ptr    = CELL_W'(MOVE_FIRST);
                    n_pend   = 1'b0;
                    n_state  = S_MOVE;
                end else begin
                    n_state = S_SPACE;
                end
            end
            S_MOVE: begin
                // read one row ahead, write the previous read one row up
                re     = 1'b1;
                ra     = r_ptr[ADDR_W-1:0];
                we     = r_pend;
                wa     = r_wa;
                wd     = r_rdata;
                n_wa   = ADDR_W'(r_ptr - CELL_W'(COLUMNS));
                n_pend = 1'b1;
                if (r_ptr == CELL_W'(MOVE_LAST)) begin
                    n_state = S_MVEND;
                end else begin
                    n_ptr = r_ptr + CELL_W'(1);
                end
            end
            S_MVEND: begin
                we     = 1'b1;
                wa     = r_wa;
                wd     = r_rdata;
                n_pend = 1'b0;
                if (r_cursor < CELL_W'(CLEAR_END)) begin
                    n_ptr   = r_cursor;
                    n_state = S_WIPE;
                end else begin
                    n_state = S_SPACE;
                end
            end
            S_WIPE: begin
                we = 1'b1;
                wa = r_ptr[ADDR_W-1:0];
                if (r_ptr == CELL_W'(CLEAR_END - 1)) begin
                    n_state = S_SPACE;
                end else begin
                    n_ptr = r_ptr + CELL_W'(1);
                end
            end
            S_SPACE: begin
                we      = 1'b1;
                wa      = r_cursor[ADDR_W-1:0];
                wd      = {r_attr, BYTE_SPACE};
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (o_res.ready) begin
                    if (r_idx == r_cmd.last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cursor <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_ptr    <= '0;
            r_pend   <= 1'b0;
            r_idx    <= '0;
            r_attr   <= ATTR_RESET;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_row    <= n_row;
            r_col    <= n_col;
            r_ptr    <= n_ptr;
            r_pend   <= n_pend;
            r_idx    <= n_idx;
            if (i_cfg.valid) begin
                r_attr <= i_cfg.text_attribute;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_cell <= n_cell;
        r_wa   <= n_wa;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_screen[wa] <= wd;
        end
        if (re) begin
            r_rdata <= r_screen[ra];
        end
    end

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_EMIT) |-> (r_cursor < CELL_W'(SCREEN_CELLS)))
        else $error("cursor beyond screen");

    a_cursor_rowcol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
            (int'(r_cursor) == int'(r_row) * COLUMNS + int'(r_col) && int'(r_col) < COLUMNS))
        else $error("cursor out of step with row and column");

    a_move_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE && r_pend) |-> (CELL_W'(r_wa) + CELL_W'(COLUMNS) < r_ptr + CELL_W'(1)))
        else $error("scroll write overtakes read");

    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_idx <= r_cmd.last_idx))
        else $error("result index past last");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && $past(r_state) == S_CLEAR) |-> (r_state == S_CLEAR))
        else $error("clearing pass left early");

endmodule

// ===== src/text_screen_console_writer.sv =====
// Top level of the text screen console writer.
// Channels: i_put takes one transaction per character code (kind 0) or per
// screen cell read (kind 1); o_res returns one or three results per item,
// the final one flagged by last; i_cfg writes the attribute byte and is
// always ready (write only while the block is idle).
// A put item yields its serial bytes (BS SP BS for backspace, ESC [ x for
// arrows, the code itself otherwise) with the cursor after the item.
// Structure: a combinational decode and a two-entry queue feed a sequential
// engine around a one-read one-write screen memory. A read passes S_RDWAIT
// on to S_EMIT (straight to S_EMIT beyond the last cell), a left or right
// arrow goes straight to S_EMIT, and a character, newline or backspace
// passes S_CHECK and S_SPACE; each further result of the same item stays
// in S_EMIT. A scroll adds S_MOVE over (SCROLL_ROW-1)*COLUMNS moved cells,
// S_MVEND and S_WIPE from the cursor to the end of row SCROLL_ROW-1.
// Reset: cursor to 0, attribute to 7, and a clearing pass writes every one
// of the COLUMNS*(SCROLL_ROW+1) = 2000 cells to 0 while i_put is not ready.
// A stalled o_res holds its result; i_put keeps taking items until the
// queue is full.
module text_screen_console_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsc_put_if.sink     i_put,
    tsc_cfg_if.sink     i_cfg,
    tsc_res_if.source   o_res
);
    import tsc_pkg::*;

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    logic clearing;
    t_cmd push_data, pop_data;

    tsc_front u_front (
        .i_put        (i_put),
        .i_clearing   (clearing),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    tsc_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    tsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_clearing  (clearing),
        .i_cfg       (i_cfg),
        .o_res       (o_res)
    );

endmodule
